// ----- hw/rtl/tmrs_pkg.sv -----
`default_nettype none

package tmrs_pkg;

  localparam int unsigned CfgW = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ModeW = 3;
  localparam int unsigned LevelW = 8;
  localparam int unsigned AddrW = 3;
  localparam int unsigned LevelNowW = 4;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned ChainDepth = 3;

  localparam logic [CfgW-1:0] AddrSettleRst = CfgW'(10);
  localparam logic [CfgW-1:0] IdleRelayRst = CfgW'(10000);
  localparam logic [CfgW-1:0] RelaySettleRst = CfgW'(50000);
  localparam logic [CfgW-1:0] ThrRegisterRst = CfgW'(100000);
  localparam logic [CfgW-1:0] RelayReleaseRst = CfgW'(20000);

  localparam logic signed [LevelNowW-1:0] LevelOff = -LevelNowW'(1);

  typedef enum logic [ModeW-1:0] {
    MODE_TICK   = 3'd0,
    MODE_SET    = 3'd1,
    MODE_DIS    = 3'd2,
    MODE_ENTER  = 3'd3,
    MODE_LEAVE  = 3'd4,
    MODE_ESTOP  = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ADDR_SETTLE   = 3'd0,
    CFG_IDLE_RELAY    = 3'd1,
    CFG_RELAY_SETTLE  = 3'd2,
    CFG_THR_REGISTER  = 3'd3,
    CFG_RELAY_RELEASE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                        accepted;
    logic                        busy_res;
    logic                        autonomous;
    logic signed [LevelNowW-1:0] level_now;
    logic                        relay_on;
    logic                        mux_enable;
    logic [AddrW-1:0]            addr_lines;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/throttle_mux_relay_sequencer.sv -----
// Throttle mux and relay sequencer.
// Input stream: tuser carries the item kind (tick, set level, disable mux,
// enter autonomous, leave autonomous, emergency stop), tdata the signed level.
// Every input transaction gives exactly one result transaction on the output
// stream: address lines, mux enable, relay drive, active level, autonomous
// flag, busy flag and whether the item was accepted.
// An item is held in an input register and its result is then registered
// in the result register, from which the output stream takes it;
// one item is taken in every cycle while results are drained.
// Chains of zero-length waits settle within the same item through three
// cascaded phase-closing steps after the input register.
// The configuration channel writes the five 20-bit tick counts, always ready;
// write only while no item is in flight.
// Reset gives the safe state: mux disabled, relay off, level -1, no sequence.
// When the output stalls, the result register and then the input register
// hold, and s_axis_tready falls once both are full.
`default_nettype none

module throttle_mux_relay_sequencer import tmrs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // level[7:0]
  input  wire logic [ModeW-1:0]    s_axis_tuser,   // mode[2:0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // addr_lines[2:0], mux_enable[3],
                                                   // relay_on[4], level_now[8:5],
                                                   // autonomous[9], busy_res[10],
                                                   // accepted[11], zeros[15:12]
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    PH_IDLE           = 4'd0,
    PH_SET_ADDR       = 4'd1,
    PH_ENTER_ADDR     = 4'd2,
    PH_ENTER_IDLE     = 4'd3,
    PH_ENTER_SETTLE   = 4'd4,
    PH_LEAVE_ADDR     = 4'd5,
    PH_LEAVE_REGISTER = 4'd6,
    PH_LEAVE_RELEASE  = 4'd7
  } phase_e;

  logic [CfgW-1:0] addr_settle_q, idle_relay_q, relay_settle_q;
  logic [CfgW-1:0] thr_register_q, relay_release_q;

  logic                    in_valid_q;
  logic [ModeW-1:0]        mode_q;
  logic signed [LevelW-1:0] level_q;

  logic    out_valid_q;
  result_t res_q, res_d;

  phase_e                      phase_q, phase_d;
  logic [CfgW-1:0]             wait_q, wait_d;
  logic [AddrW-1:0]            addr_q, addr_d;
  logic                        enable_q, enable_d;
  logic                        relay_q, relay_d;
  logic signed [LevelNowW-1:0] active_q, active_d;
  logic [AddrW-1:0]            pend_q, pend_d;
  logic                        auto_q, auto_d;

  logic advance;
  logic take_in;
  logic acc;
  logic run;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), res_q};

  always_comb begin
    phase_d  = phase_q;
    wait_d   = wait_q;
    addr_d   = addr_q;
    enable_d = enable_q;
    relay_d  = relay_q;
    active_d = active_q;
    pend_d   = pend_q;
    auto_d   = auto_q;
    acc      = 1'b1;
    run      = 1'b0;

    unique case (mode_q)
      MODE_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (wait_q != '0) wait_d = wait_q - CfgW'(1);
          run = 1'b1;
        end
      end
      MODE_ESTOP: begin
        enable_d = 1'b0;
        relay_d  = 1'b0;
        active_d = LevelOff;
        auto_d   = 1'b0;
        phase_d  = PH_IDLE;
        wait_d   = '0;
      end
      MODE_SET, MODE_DIS, MODE_ENTER, MODE_LEAVE: begin
        if (phase_q != PH_IDLE) begin
          acc = 1'b0;
        end else if (mode_q == MODE_SET && level_q[LevelW-1:AddrW] == '0) begin
          addr_d  = level_q[AddrW-1:0];
          pend_d  = level_q[AddrW-1:0];
          phase_d = PH_SET_ADDR;
          wait_d  = addr_settle_q;
          run     = 1'b1;
        end else if (mode_q == MODE_SET || mode_q == MODE_DIS) begin
          enable_d = 1'b0;
          active_d = LevelOff;
        end else begin
          addr_d  = '0;
          pend_d  = '0;
          phase_d = (mode_q == MODE_ENTER) ? PH_ENTER_ADDR : PH_LEAVE_ADDR;
          wait_d  = addr_settle_q;
          run     = 1'b1;
        end
      end
      default: acc = 1'b0;
    endcase

    // close phases whose wait has run out
    for (int i = 0; i < ChainDepth; i++) begin
      if (run && phase_d != PH_IDLE && wait_d == '0) begin
        unique case (phase_d)
          PH_SET_ADDR: begin
            enable_d = 1'b1;
            active_d = {1'b0, pend_d};
            phase_d  = PH_IDLE;
            wait_d   = '0;
          end
          PH_ENTER_ADDR: begin
            enable_d = 1'b1;
            active_d = '0;
            phase_d  = PH_ENTER_IDLE;
            wait_d   = idle_relay_q;
          end
          PH_ENTER_IDLE: begin
            relay_d = 1'b1;
            auto_d  = 1'b1;
            phase_d = PH_ENTER_SETTLE;
            wait_d  = relay_settle_q;
          end
          PH_LEAVE_ADDR: begin
            enable_d = 1'b1;
            active_d = '0;
            phase_d  = PH_LEAVE_REGISTER;
            wait_d   = thr_register_q;
          end
          PH_LEAVE_REGISTER: begin
            relay_d = 1'b0;
            auto_d  = 1'b0;
            phase_d = PH_LEAVE_RELEASE;
            wait_d  = relay_release_q;
          end
          PH_LEAVE_RELEASE: begin
            enable_d = 1'b0;
            active_d = LevelOff;
            phase_d  = PH_IDLE;
            wait_d   = '0;
          end
          default: begin
            phase_d = PH_IDLE;
            wait_d  = '0;
          end
        endcase
      end
    end

    res_d.addr_lines = addr_d;
    res_d.mux_enable = enable_d;
    res_d.relay_on   = relay_d;
    res_d.level_now  = active_d;
    res_d.autonomous = auto_d;
    res_d.busy_res   = (phase_d != PH_IDLE);
    res_d.accepted   = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_settle_q   <= AddrSettleRst;
      idle_relay_q    <= IdleRelayRst;
      relay_settle_q  <= RelaySettleRst;
      thr_register_q  <= ThrRegisterRst;
      relay_release_q <= RelayReleaseRst;
      in_valid_q      <= 1'b0;
      mode_q          <= '0;
      level_q         <= '0;
      out_valid_q     <= 1'b0;
      res_q           <= '0;
      phase_q         <= PH_IDLE;
      wait_q          <= '0;
      addr_q          <= '0;
      enable_q        <= 1'b0;
      relay_q         <= 1'b0;
      active_q        <= LevelOff;
      pend_q          <= '0;
      auto_q          <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ADDR_SETTLE:   addr_settle_q   <= cfg_data_i;
          CFG_IDLE_RELAY:    idle_relay_q    <= cfg_data_i;
          CFG_RELAY_SETTLE:  relay_settle_q  <= cfg_data_i;
          CFG_THR_REGISTER:  thr_register_q  <= cfg_data_i;
          CFG_RELAY_RELEASE: relay_release_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (take_in) begin
        in_valid_q <= 1'b1;
        mode_q     <= s_axis_tuser;
        level_q    <= s_axis_tdata;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        res_q       <= res_d;
        phase_q     <= phase_d;
        wait_q      <= wait_d;
        addr_q      <= addr_d;
        enable_q    <= enable_d;
        relay_q     <= relay_d;
        active_q    <= active_d;
        pend_q      <= pend_d;
        auto_q      <= auto_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
